>>> hw/rtl/sacl_pkg.sv
// Shared types and constants for the LFU set-associative read cache.
// Holds the request/result payload structs, line metadata and FSM state.
// No dependencies.
package sacl_pkg;

  // Fixed geometry of the storage
  localparam int MAX_SETS        = 16;
  localparam int MAX_WAYS        = 4;
  localparam int MAX_BLOCK_BYTES = 8;
  localparam int MEM_BYTES       = 1024;

  localparam int SET_LOG2 = $clog2(MAX_SETS);
  localparam int SET_W    = SET_LOG2;
  localparam int WAY_W    = $clog2(MAX_WAYS);
  localparam int BLK_LOG2 = $clog2(MAX_BLOCK_BYTES);
  localparam int OFF_W    = BLK_LOG2;
  localparam int LINES    = MAX_SETS * MAX_WAYS;
  localparam int LINE_W   = $clog2(LINES);
  localparam int ADDR_W   = $clog2(MEM_BYTES);
  localparam int TAG_W    = 10;
  localparam int CNT_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [9:0]        address;
    logic [7:0]        write_data;
  } sacl_in_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              hit;
    logic [1:0]        way_used;
  } sacl_out_t;

  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  cnt;
    logic [TAG_W-1:0]  tag;
  } sacl_meta_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_DONE
  } sacl_state_t;

endpackage

>>> hw/rtl/set_assoc_cache_lfu_read.sv
// Top level of the LFU set-associative read cache with its byte backing memory.
// Depends on sacl_pkg for payload types, line metadata and FSM states.
//
//  channel  | ports                          | direction | moves
//  ---------+--------------------------------+-----------+---------------------------
//  in       | in_valid, in_stall, in_data    | input     | load or read request
//  out      | out_valid, out_stall, out_data | output    | one result per request
//  cfg      | cfg_we, cfg_index, cfg_wdata   | input     | geometry register write
//
// One request at a time; once its result is loaded into the output register, the block
// returns to idle and takes the next request. A load writes the backing memory and goes
// straight to the result. A read checks one way per cycle out of the registered
// metadata/line memory reads: a hit ends the scan at that way; a miss scans every way, then
// refills the line one byte per cycle through the single backing memory read port.
// After reset a clearing pass over all 64 lines zeroes the line memories; in_stall is high.
// A finished result waits in the output register; the next request is taken meanwhile,
// and its result holds in_stall high until the output register frees up.
module set_assoc_cache_lfu_read (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  sacl_pkg::sacl_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sacl_pkg::sacl_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sacl_pkg::CFG_DAT_W-1:0]       cfg_wdata
);
  import sacl_pkg::*;

  // Configuration registers
  logic [2:0] set_bits_r;
  logic [3:0] tag_bits_r;
  logic [1:0] block_bits_r;
  logic [2:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd2;
      tag_bits_r   <= 4'd4;
      block_bits_r <= 2'd2;
      ways_r       <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_wdata[2:0];
        CFG_TAG_BITS:   tag_bits_r   <= cfg_wdata[3:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[1:0];
        CFG_WAYS:       ways_r       <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Control and payload registers
  sacl_state_t            state_r, state_nxt;
  sacl_in_t               req_r, req_nxt;
  logic [LINE_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [WAY_W:0]         iss_way_r, iss_way_nxt;
  logic                   pend_r, pend_nxt;
  logic [WAY_W-1:0]       pend_way_r, pend_way_nxt;
  logic [CNT_W-1:0]       min_cnt_r, min_cnt_nxt;
  logic [WAY_W-1:0]       victim_r, victim_nxt;
  logic [BYTE_W-1:0]      mem_byte_r, mem_byte_nxt;
  logic [OFF_W:0]         fill_idx_r, fill_idx_nxt;
  logic                   fill_pend_r, fill_pend_nxt;
  logic [OFF_W-1:0]       fill_pos_r, fill_pos_nxt;
  sacl_out_t              res_r, res_nxt;
  logic                   out_valid_r;
  sacl_out_t              out_data_r;
  logic                   out_load;

  // Effective geometry
  logic [2:0]             s_eff;
  logic [1:0]             b_eff;
  logic [2:0]             nw;
  logic [3:0]             tag_sh;
  logic [ADDR_W-1:0]      set_full;
  logic [SET_W-1:0]       set_idx;
  logic [TAG_W-1:0]       tag;
  logic [OFF_W-1:0]       blk_last;
  logic [OFF_W-1:0]       off;
  logic [ADDR_W-1:0]      base;

  always_comb begin
    s_eff    = (set_bits_r > 3'(SET_LOG2)) ? 3'(SET_LOG2) : set_bits_r;
    b_eff    = ({1'b0, block_bits_r} > 3'(BLK_LOG2)) ? 2'(BLK_LOG2) : block_bits_r;
    nw       = (ways_r == 3'd0) ? 3'd1 :
               (ways_r > 3'(MAX_WAYS)) ? 3'(MAX_WAYS) : ways_r;
    tag_sh   = {1'b0, s_eff} + {2'b00, b_eff};
    set_full = (req_r.address >> b_eff) & ~({ADDR_W{1'b1}} << s_eff);
    set_idx  = set_full[SET_W-1:0];
    tag      = TAG_W'((req_r.address >> tag_sh) & ~({ADDR_W{1'b1}} << tag_bits_r));
    blk_last = ~({OFF_W{1'b1}} << b_eff);
    off      = req_r.address[OFF_W-1:0] & blk_last;
    base     = req_r.address & ({ADDR_W{1'b1}} << b_eff);
  end

  // Line metadata memory
  sacl_meta_t             meta_mem [LINES];
  sacl_meta_t             meta_rd_r;
  logic                   meta_we;
  logic [LINE_W-1:0]      meta_wa;
  sacl_meta_t             meta_wd;
  logic [LINE_W-1:0]      line_ra;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    meta_rd_r <= meta_mem[line_ra];
  end

  // Line data memory, one row per line with byte writes
  logic [MAX_BLOCK_BYTES-1:0][BYTE_W-1:0] data_mem [LINES];
  logic [MAX_BLOCK_BYTES-1:0][BYTE_W-1:0] data_rd_r;
  logic                   data_we;
  logic                   data_clr;
  logic [LINE_W-1:0]      data_wa;
  logic [OFF_W-1:0]       data_wbyte;
  logic [BYTE_W-1:0]      data_wd;

  always_ff @(posedge clk) begin
    if (data_clr) begin
      data_mem[data_wa] <= '0;
    end else if (data_we) begin
      data_mem[data_wa][data_wbyte] <= data_wd;
    end
    data_rd_r <= data_mem[line_ra];
  end

  // Backing memory
  logic [BYTE_W-1:0]      bm_mem [MEM_BYTES];
  logic [BYTE_W-1:0]      bm_rd_r;
  logic                   bm_we;
  logic [ADDR_W-1:0]      bm_wa;
  logic [BYTE_W-1:0]      bm_wd;
  logic [ADDR_W-1:0]      bm_ra;

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_wa] <= bm_wd;
    end
    bm_rd_r <= bm_mem[bm_ra];
  end

  // Way check on the returned row
  logic way_hit;
  logic new_min;

  always_comb begin
    way_hit = meta_rd_r.valid && (meta_rd_r.tag == tag) && (data_rd_r[off] == bm_rd_r);
    new_min = (pend_way_r == '0) || (meta_rd_r.cnt < min_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      fill_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      fill_pend_r <= fill_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    iss_way_r  <= iss_way_nxt;
    pend_way_r <= pend_way_nxt;
    min_cnt_r  <= min_cnt_nxt;
    victim_r   <= victim_nxt;
    mem_byte_r <= mem_byte_nxt;
    fill_idx_r <= fill_idx_nxt;
    fill_pos_r <= fill_pos_nxt;
    res_r      <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    clr_cnt_nxt   = clr_cnt_r;
    iss_way_nxt   = iss_way_r;
    pend_nxt      = pend_r;
    pend_way_nxt  = pend_way_r;
    min_cnt_nxt   = min_cnt_r;
    victim_nxt    = victim_r;
    mem_byte_nxt  = mem_byte_r;
    fill_idx_nxt  = fill_idx_r;
    fill_pend_nxt = fill_pend_r;
    fill_pos_nxt  = fill_pos_r;
    res_nxt       = res_r;
    out_load      = 1'b0;
    in_stall      = 1'b1;

    meta_we    = 1'b0;
    meta_wa    = {set_idx, pend_way_r};
    meta_wd    = '0;
    line_ra    = {set_idx, iss_way_r[WAY_W-1:0]};
    data_we    = 1'b0;
    data_clr   = 1'b0;
    data_wa    = {set_idx, victim_r};
    data_wbyte = fill_pos_r;
    data_wd    = bm_rd_r;
    bm_we      = 1'b0;
    bm_wa      = in_data.address;
    bm_wd      = in_data.write_data;
    bm_ra      = req_r.address;

    case (state_r)
      S_CLR: begin
        meta_we     = 1'b1;
        meta_wa     = clr_cnt_r;
        data_clr    = 1'b1;
        data_wa     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LINE_W'(LINES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt = in_data;
          if (in_data.req_type == REQ_LOAD) begin
            bm_we     = 1'b1;
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            iss_way_nxt = '0;
            pend_nxt    = 1'b0;
            state_nxt   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next way while checking the one read last cycle
        if (iss_way_r < nw) begin
          iss_way_nxt  = iss_way_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_way_nxt = iss_way_r[WAY_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (way_hit) begin
            meta_we   = 1'b1;
            meta_wd   = '{valid: 1'b1, cnt: meta_rd_r.cnt + 1'b1, tag: meta_rd_r.tag};
            res_nxt   = '{read_data: bm_rd_r, hit: 1'b1, way_used: pend_way_r};
            pend_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else begin
            if (new_min) begin
              min_cnt_nxt = meta_rd_r.cnt;
              victim_nxt  = pend_way_r;
            end
            if ({1'b0, pend_way_r} == nw - 3'd1) begin
              mem_byte_nxt  = bm_rd_r;
              fill_idx_nxt  = '0;
              fill_pend_nxt = 1'b0;
              pend_nxt      = 1'b0;
              state_nxt     = S_FILL;
            end
          end
        end
      end

      S_FILL: begin
        bm_ra = base | ADDR_W'(fill_idx_r[OFF_W-1:0]);
        if (fill_idx_r <= {1'b0, blk_last}) begin
          fill_idx_nxt  = fill_idx_r + 1'b1;
          fill_pend_nxt = 1'b1;
          fill_pos_nxt  = fill_idx_r[OFF_W-1:0];
        end else begin
          fill_pend_nxt = 1'b0;
        end
        if (fill_pend_r) begin
          data_we = 1'b1;
          if (fill_pos_r == blk_last) begin
            meta_we       = 1'b1;
            meta_wa       = {set_idx, victim_r};
            meta_wd       = '{valid: 1'b1, cnt: CNT_W'(1), tag: tag};
            res_nxt       = '{read_data: mem_byte_r, hit: 1'b0, way_used: victim_r};
            fill_pend_nxt = 1'b0;
            state_nxt     = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Hand the result over once the output register frees up
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/sacl_checker.sv
// Port-level checks for set_assoc_cache_lfu_read, bound onto the top level.
// Depends on sacl_pkg for the result payload type.
module sacl_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input sacl_pkg::sacl_out_t  out_data
);
  import sacl_pkg::*;

  // Reset starts the clearing pass: no request taken, no result shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("request taken or result shown right after reset");

  // One request at a time: the cycle after an accept stalls the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted back to back");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A new result only shows up while a request is in progress
  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without request in progress");

endmodule

bind set_assoc_cache_lfu_read sacl_checker u_sacl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/tb_set_assoc_cache_lfu_read.sv
// Self-checking testbench for the LFU set-associative read cache.
// Depends on sacl_pkg and set_assoc_cache_lfu_read; mirrors the cache state to
// predict each result and compares it with what leaves the block.
module tb_set_assoc_cache_lfu_read;
  timeunit 1ns;
  timeprecision 1ps;

  import sacl_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sacl_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sacl_out_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SET_BITS;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  set_assoc_cache_lfu_read dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the cache geometry and contents
  logic [2:0]  geo_set_bits = 3'd2;
  logic [3:0]  geo_tag_bits = 4'd4;
  logic [1:0]  geo_block_bits = 2'd2;
  logic [2:0]  geo_ways = 3'd2;
  bit          line_ok    [LINES];
  bit [7:0]    line_cnt   [LINES];
  bit [9:0]    line_tag   [LINES];
  bit [7:0]    line_bytes [LINES*MAX_BLOCK_BYTES];
  bit [7:0]    mem_bytes  [MEM_BYTES];

  // Stimulus bookkeeping
  bit          loaded [MEM_BYTES];
  sacl_in_t    pending_reqs[$];
  sacl_out_t   pending_results[$];
  sacl_out_t   want_res;
  int          n_errors = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  logic        rx_hold_start = 1'b0;
  logic [7:0]  rx_hold_cnt = '0;

  function automatic sacl_out_t cache_access(sacl_in_t r);
    int addr, sb, bb, nw, set_idx, tag, off, ln, victim, w, i;
    bit [7:0] mem_byte;
    sacl_out_t res;
    res = '0;
    addr = int'(r.address);
    if (r.req_type == REQ_LOAD) begin
      mem_bytes[addr] = r.write_data;
      return res;
    end
    sb = (geo_set_bits > SET_LOG2) ? SET_LOG2 : int'(geo_set_bits);
    bb = (geo_block_bits > BLK_LOG2) ? BLK_LOG2 : int'(geo_block_bits);
    nw = (geo_ways == 0) ? 1 : ((geo_ways > MAX_WAYS) ? MAX_WAYS : int'(geo_ways));
    set_idx = (addr >> bb) & ((1 << sb) - 1);
    tag = (addr >> (sb + bb)) & ((1 << geo_tag_bits) - 1);
    off = addr & ((1 << bb) - 1);
    mem_byte = mem_bytes[addr];
    for (w = 0; w < nw; w++) begin
      ln = set_idx * MAX_WAYS + w;
      if (line_ok[ln] && line_tag[ln] == tag &&
          line_bytes[ln*MAX_BLOCK_BYTES + off] == mem_byte) begin
        line_cnt[ln] = line_cnt[ln] + 8'd1;
        res.read_data = mem_byte;
        res.hit = 1'b1;
        res.way_used = w[1:0];
        return res;
      end
    end
    // lowest use count wins, first way on ties
    victim = 0;
    for (w = 1; w < nw; w++) begin
      if (line_cnt[set_idx*MAX_WAYS + w] < line_cnt[set_idx*MAX_WAYS + victim]) begin
        victim = w;
      end
    end
    ln = set_idx * MAX_WAYS + victim;
    line_cnt[ln] = 8'd1;
    line_ok[ln] = 1'b1;
    line_tag[ln] = tag[9:0];
    for (i = 0; i < (1 << bb); i++) begin
      line_bytes[ln*MAX_BLOCK_BYTES + i] = mem_bytes[((addr - off) + i) % MEM_BYTES];
    end
    res.read_data = mem_byte;
    res.way_used = victim[1:0];
    return res;
  endfunction

  // Driver: offer queued requests, hold while stalled, idle in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(cache_access(in_data));
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && tx_idle_on && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_cnt <= '0;
    end else if (rx_hold_start) begin
      rx_hold_cnt <= 8'd120;
    end else if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 8'd1;
    end
  end

  // Monitor: check each result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: %p", out_data);
          n_errors++;
        end else begin
          want_res = pending_results.pop_front();
          if (out_data.read_data !== want_res.read_data) begin
            $error("read_data: expected %0d, got %0d", want_res.read_data, out_data.read_data);
            n_errors++;
          end
          if (out_data.hit !== want_res.hit) begin
            $error("hit: expected %0d, got %0d", want_res.hit, out_data.hit);
            n_errors++;
          end
          if (out_data.way_used !== want_res.way_used) begin
            $error("way_used: expected %0d, got %0d", want_res.way_used, out_data.way_used);
            n_errors++;
          end
        end
      end
      if (rx_hold_cnt != 0) begin
        out_stall <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_load(input int a, input int d);
    sacl_in_t r;
    r.req_type = REQ_LOAD;
    r.address = ADDR_W'(a);
    r.write_data = BYTE_W'(d);
    pending_reqs.push_back(r);
    loaded[a] = 1'b1;
  endtask

  // Load whatever is still missing of the block first, so no refill sees unwritten memory
  task automatic push_read(input int a);
    sacl_in_t r;
    int bsz, base, i;
    bsz = 1 << geo_block_bits;
    base = a & ~(bsz - 1);
    for (i = 0; i < bsz; i++) begin
      if (!loaded[base + i]) begin
        push_load(base + i, $urandom_range(0, 255));
      end
    end
    r.req_type = REQ_READ;
    r.address = ADDR_W'(a);
    r.write_data = BYTE_W'($urandom_range(0, 255));
    pending_reqs.push_back(r);
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DAT_W'(val);
    case (idx)
      CFG_SET_BITS:   geo_set_bits = val[2:0];
      CFG_TAG_BITS:   geo_tag_bits = val[3:0];
      CFG_BLOCK_BITS: geo_block_bits = val[1:0];
      CFG_WAYS:       geo_ways = val[2:0];
      default: ;
    endcase
  endtask

  // Drain, then rewrite the whole geometry
  task automatic set_geometry(input int s, input int t, input int b, input int w);
    wait_quiet();
    write_reg(CFG_SET_BITS, s);
    write_reg(CFG_TAG_BITS, t);
    write_reg(CFG_BLOCK_BITS, b);
    write_reg(CFG_WAYS, w);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Working set clustered on shared low bits so that sets see tag conflicts
  task automatic random_traffic(input int n_items);
    int pool [12];
    int low, a, pick, i;
    low = $urandom_range(0, 63);
    for (i = 0; i < 12; i++) begin
      pool[i] = (i < 8) ? (($urandom_range(0, 15) << 6) | low) : $urandom_range(0, MEM_BYTES-1);
    end
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      a = pool[$urandom_range(0, 11)];
      if ($urandom_range(0, 3) == 0) begin
        a = a ^ $urandom_range(0, 7);
      end
      if (pick < 60) begin
        push_read(a);
      end else if (pick < 72) begin
        push_read($urandom_range(0, MEM_BYTES-1));
      end else if (pick < 92) begin
        push_load(a, $urandom_range(0, 255));
      end else begin
        push_load($urandom_range(0, MEM_BYTES-1), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    int a_addr, b_addr, c_addr, i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the clearing pass is over
    do @(negedge clk);
    while (!rst_n || in_stall);

    // One set, two ways, two-byte blocks: invalid lines, block hits, LFU choice, stale byte
    set_geometry(0, 10, 1, 2);
    push_load(0, 8'h00);
    push_load(1, 8'hFF);
    push_load(1022, 8'hFF);
    push_load(1023, 8'h00);
    push_read(0);
    push_read(1);
    push_read(1023);
    push_read(1022);
    push_read(1023);
    push_read(2);
    push_load(1023, 8'hA5);
    push_read(1023);
    // geometry changes keep the lines
    set_geometry(0, 10, 1, 4);
    push_read(1022);
    push_read(3);
    set_geometry(0, 10, 1, 1);
    push_read(1022);
    push_read(0);

    // reset geometry, with the receiver held off long enough to back up the input
    set_geometry(2, 4, 2, 2);
    random_traffic(25);
    @(posedge clk);
    rx_hold_start <= 1'b1;
    @(posedge clk);
    rx_hold_start <= 1'b0;

    set_geometry(4, 15, 3, 4);
    random_traffic(25);
    set_geometry(7, 0, 0, 0);
    random_traffic(25);
    set_geometry(15, 3, 3, 7);
    random_traffic(25);

    // use count wraps to zero after 255 hits and then loses the LFU choice
    set_geometry(0, 10, 0, 2);
    a_addr = $urandom_range(0, MEM_BYTES-1);
    b_addr = (a_addr + 1 + $urandom_range(0, 500)) % MEM_BYTES;
    c_addr = (b_addr + 1 + $urandom_range(0, 500)) % MEM_BYTES;
    push_read(a_addr);
    push_read(b_addr);
    for (i = 0; i < 255; i++) begin
      push_read(a_addr);
    end
    push_read(c_addr);
    push_read(b_addr);
    push_read(a_addr);

    set_geometry(1, 2, 2, 1);
    random_traffic(25);
    set_geometry(3, 6, 1, 3);
    random_traffic(25);

    // last stretch at full rate
    set_geometry(4, 10, 3, 4);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_traffic(25);

    wait_quiet();
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
